// ----- hw/rtl/ntc_beta_temperature_core_assert.svh -----
// Assertion macros shared by the thermistor core RTL.
`ifndef NTC_BETA_TEMPERATURE_CORE_ASSERT_SVH
`define NTC_BETA_TEMPERATURE_CORE_ASSERT_SVH

// Same-cycle implication.
`define NTCBT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTCBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ntcbt_pkg.sv -----
// Shared types and constants for the thermistor temperature core.
`default_nettype none
package ntcbt_pkg;
  localparam int ADC_FULL_SCALE_DEF = 4095;

  localparam int CODE_W   = 12;
  localparam int BETA_W   = 14;
  localparam int T0_W     = 16;
  localparam int TEMP_W   = 16;
  localparam int STATUS_W = 2;
  localparam int RATIO_W  = 32;
  localparam int LN_W     = 22;
  localparam int KCFG_W   = 37;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [STATUS_W-1:0] STATUS_VALID     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CODE_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CODE_FULL = 2'd2;

  localparam logic REG_BETA         = 1'b0;
  localparam logic REG_NOMINAL_TEMP = 1'b1;

  localparam logic [BETA_W-1:0] BETA_RESET = 14'd3905;
  localparam logic [T0_W-1:0]   T0_RESET   = 16'd29815;

  localparam logic [31:0] LN2_Q32          = 32'd2977044472;
  localparam logic [22:0] BETA_SCALE       = 23'd6553600;
  localparam logic [6:0]  CENTI_SCALE      = 7'd100;
  localparam logic [17:0] KELVIN_OFFSET_CK = 18'd27315;
  localparam logic [15:0] TEMP_MAX_CC      = 16'd32767;

  // register stages per unit
  localparam int RATIO_LAT = 33;
  localparam int LOG_LAT   = 21;
  localparam int TEMP_LAT  = 22;
  localparam int TOTAL_LAT = RATIO_LAT + LOG_LAT + TEMP_LAT;

  typedef struct packed {
    logic [KCFG_W-1:0] num_base;  // 100 * beta * T0
    logic [KCFG_W-1:0] beta_k;    // 6553600 * beta
    logic [T0_W-1:0]   t0;
  } cfg_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ntc_beta_temperature_core.sv -----
// Top level of the NTC thermistor beta-equation temperature core.
`default_nettype none
`include "ntc_beta_temperature_core_assert.svh"
// Converts one ADC code from a thermistor divider (series resistor equal to
// the nominal resistance) into temperature in 0.01 degC via the beta equation.
// A request is taken on any cycle with start high; busy is always low, so one
// request per clock is sustained. The result appears on temp_centi_celsius and
// status for exactly one cycle, flagged by done, when the request leaves the
// pipeline (ntcbt_pkg::TOTAL_LAT). The receiver cannot stall; results must be
// captured in the done cycle. The datapath is three pipelined units:
//   - ratio: 32-stage radix-2 divider, (full_scale - code) * 2^16 / code
//   - log:   leading-one search, 16 squaring stages (one 31x31 multiply each)
//            for the log2 fraction, then a multiply by ln2 and rounding
//   - temp:  ln * T0 + beta term, an 18-stage restoring divider for the
//            rounded quotient (first stage flags overflow), clamp to range
// status: 0 valid, 1 code was zero, 2 code at or above full scale; on a
// nonzero status the temperature reads 0. Registers (APB, byte addresses):
// 0x0 beta_coefficient, 0x4 nominal_temp_centikelvin. Write them only with no
// request in flight; derived products are registered from them.
module ntc_beta_temperature_core #(
  parameter int ADC_FULL_SCALE = ntcbt_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic [ntcbt_pkg::CODE_W-1:0]        adc_code,
  // result channel
  output logic                                done,
  output logic signed [ntcbt_pkg::TEMP_W-1:0] temp_centi_celsius,
  output logic [ntcbt_pkg::STATUS_W-1:0]      status,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ntcbt_pkg::ADDR_W-1:0]        paddr,
  input  logic [ntcbt_pkg::DATA_W-1:0]        pwdata,
  output logic [ntcbt_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);
  import ntcbt_pkg::*;

  logic                accept;
  cfg_t                cfg;

  logic                rat_valid;
  logic [RATIO_W-1:0]  rat;
  logic [STATUS_W-1:0] rat_status;

  logic                ln_valid;
  logic signed [LN_W-1:0] ln_val;
  logic [STATUS_W-1:0] ln_status;

  // fully pipelined: never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ntcbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ntcbt_ratio #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_ratio (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .adc_code   (adc_code),
    .out_valid  (rat_valid),
    .ratio      (rat),
    .out_status (rat_status)
  );

  ntcbt_log u_log (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rat_valid),
    .ratio      (rat),
    .in_status  (rat_status),
    .out_valid  (ln_valid),
    .ln         (ln_val),
    .out_status (ln_status)
  );

  ntcbt_temp u_temp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ln_valid),
    .ln         (ln_val),
    .in_status  (ln_status),
    .cfg        (cfg),
    .out_valid  (done),
    .temp       (temp_centi_celsius),
    .out_status (status)
  );

  `NTCBT_ASSERT_IMPLIES(a_done_has_request, clk, rst, done,
    $past(accept, TOTAL_LAT), "result without a matching request")
  `NTCBT_ASSERT_IMPLIES(a_flagged_zero, clk, rst, done && status != STATUS_VALID,
    temp_centi_celsius == '0, "flagged result carries a temperature")
  `NTCBT_ASSERT_IMPLIES(a_temp_floor, clk, rst, done && status == STATUS_VALID,
    temp_centi_celsius >= -16'sd27315, "temperature below absolute zero")
endmodule
`default_nettype wire

// ----- hw/rtl/ntcbt_regs.sv -----
// APB register file plus registered products of the configuration.
`default_nettype none
`include "ntc_beta_temperature_core_assert.svh"
module ntcbt_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ntcbt_pkg::ADDR_W-1:0] paddr,
  input  logic [ntcbt_pkg::DATA_W-1:0] pwdata,
  output logic [ntcbt_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output ntcbt_pkg::cfg_t              cfg
);
  import ntcbt_pkg::*;

  logic              wr;
  logic [BETA_W-1:0] beta;
  logic [T0_W-1:0]   t0;
  logic [29:0]       bt;
  logic [KCFG_W-1:0] num_base;
  logic [KCFG_W-1:0] beta_k;
  logic [T0_W-1:0]   t0_q;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= BETA_RESET;
      t0   <= T0_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_BETA:         beta <= pwdata[BETA_W-1:0];
        REG_NOMINAL_TEMP: t0   <= pwdata[T0_W-1:0];
        default:          ;
      endcase
    end
  end

  // products are registered after a write, num_base through bt first
  always_ff @(posedge clk) begin
    bt       <= {16'd0, beta} * {14'd0, t0};
    num_base <= {7'd0, bt} * {30'd0, CENTI_SCALE};
    beta_k   <= {23'd0, beta} * {14'd0, BETA_SCALE};
    t0_q     <= t0;
  end

  assign cfg = '{num_base: num_base, beta_k: beta_k, t0: t0_q};

  always_comb begin
    unique case (paddr[2])
      REG_BETA:         prdata = {{(DATA_W-BETA_W){1'b0}}, beta};
      REG_NOMINAL_TEMP: prdata = {{(DATA_W-T0_W){1'b0}}, t0};
      default:          prdata = '0;
    endcase
  end

  `NTCBT_ASSERT_NEXT(a_beta_write, clk, rst, wr && paddr[2] == REG_BETA,
    beta == $past(pwdata[BETA_W-1:0]), "beta register missed a write")
  `NTCBT_ASSERT_NEXT(a_t0_write, clk, rst, wr && paddr[2] == REG_NOMINAL_TEMP,
    t0 == $past(pwdata[T0_W-1:0]), "nominal temp register missed a write")
  `NTCBT_ASSERT_NEXT(a_regs_hold, clk, rst, !wr,
    $stable(beta) && $stable(t0), "register changed without a write")
endmodule
`default_nettype wire

// ----- hw/rtl/ntcbt_ratio.sv -----
// Range check and pipelined radix-2 divider for the resistance ratio.
`default_nettype none
module ntcbt_ratio #(
  parameter int ADC_FULL_SCALE = ntcbt_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [ntcbt_pkg::CODE_W-1:0]   adc_code,
  output logic                           out_valid,
  output logic [ntcbt_pkg::RATIO_W-1:0]  ratio,
  output logic [ntcbt_pkg::STATUS_W-1:0] out_status
);
  import ntcbt_pkg::*;

  localparam int QW = RATIO_W;
  localparam logic [15:0] FS = 16'(ADC_FULL_SCALE);

  logic                vld [0:QW];
  logic [QW-1:0]       nq  [0:QW];  // dividend bits out the top, quotient in
  logic [CODE_W-1:0]   rem [0:QW];
  logic [CODE_W-1:0]   dv  [0:QW];
  logic [STATUS_W-1:0] st  [0:QW];

  logic [15:0]         diff;
  logic [STATUS_W-1:0] stat;

  assign diff = FS - {4'd0, adc_code};

  always_comb begin
    priority if (adc_code == '0)         stat = STATUS_CODE_ZERO;
    else if ({4'd0, adc_code} >= FS)     stat = STATUS_CODE_FULL;
    else                                 stat = STATUS_VALID;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    nq[0]  <= {diff, 16'd0};
    rem[0] <= '0;
    dv[0]  <= adc_code;
    st[0]  <= stat;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [CODE_W:0] t;
    logic            ge;
    logic [CODE_W:0] t_sub;

    assign t     = {rem[k-1], nq[k-1][QW-1]};
    assign ge    = t >= {1'b0, dv[k-1]};
    assign t_sub = t - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? t_sub[CODE_W-1:0] : t[CODE_W-1:0];
      nq[k]  <= {nq[k-1][QW-2:0], ge};
      dv[k]  <= dv[k-1];
      st[k]  <= st[k-1];
    end
  end

  assign out_valid  = vld[QW];
  assign ratio      = nq[QW];
  assign out_status = st[QW];
endmodule
`default_nettype wire

// ----- hw/rtl/ntcbt_log.sv -----
// Pipelined log2 by repeated squaring, then scaling to natural log.
`default_nettype none
module ntcbt_log (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [ntcbt_pkg::RATIO_W-1:0]  ratio,
  input  logic [ntcbt_pkg::STATUS_W-1:0] in_status,
  output logic                           out_valid,
  output logic signed [ntcbt_pkg::LN_W-1:0] ln,
  output logic [ntcbt_pkg::STATUS_W-1:0] out_status
);
  import ntcbt_pkg::*;

  localparam int NSQ = 16;

  // leading one search
  logic [RATIO_W-1:0]  r;
  logic [4:0]          p_find;
  logic                va;
  logic [RATIO_W-1:0]  ra;
  logic [4:0]          pa;
  logic [STATUS_W-1:0] sta;
  logic [61:0]         shifted;

  // squaring chain
  logic                vld [0:NSQ];
  logic [30:0]         m   [0:NSQ];
  logic [NSQ-1:0]      fr  [0:NSQ];
  logic [4:0]          p   [0:NSQ];
  logic [STATUS_W-1:0] st  [0:NSQ];

  // ln tail
  logic [5:0]          ip;
  logic signed [21:0]  l2;
  logic [21:0]         a_full;
  logic                vc, vd, ve;
  logic                negc, negd;
  logic [20:0]         ac;
  logic [52:0]         prod;
  logic [52:0]         rnd;
  logic [20:0]         mag;
  logic [STATUS_W-1:0] stc, std, ste;

  assign r = (ratio == '0) ? RATIO_W'(1) : ratio;

  always_comb begin
    p_find = '0;
    for (int i = 0; i < RATIO_W; i++) begin
      if (r[i]) p_find = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= in_valid;
  end

  always_ff @(posedge clk) begin
    ra  <= r;
    pa  <= p_find;
    sta <= in_status;
  end

  // mantissa to Q1.30
  assign shifted = {ra, 30'd0} >> pa;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= va;
  end

  always_ff @(posedge clk) begin
    m[0]  <= shifted[30:0];
    fr[0] <= '0;
    p[0]  <= pa;
    st[0] <= sta;
  end

  for (genvar k = 1; k <= NSQ; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] s;

    assign sq = {31'd0, m[k-1]} * {31'd0, m[k-1]};
    assign s  = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      m[k]  <= s[31] ? s[31:1] : s[30:0];
      fr[k] <= {fr[k-1][NSQ-2:0], s[31]};
      p[k]  <= p[k-1];
      st[k] <= st[k-1];
    end
  end

  assign ip     = {1'b0, p[NSQ]} - 6'd16;
  assign l2     = $signed({ip, fr[NSQ]});
  assign a_full = ip[5] ? 22'(-l2) : 22'(l2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      vc <= vld[NSQ];
      vd <= vc;
      ve <= vd;
    end
  end

  assign rnd = prod + (53'd1 << 31);
  assign mag = rnd[52:32];

  always_ff @(posedge clk) begin
    negc <= ip[5];
    ac   <= a_full[20:0];
    stc  <= st[NSQ];
    prod <= {32'd0, ac} * {21'd0, LN2_Q32};
    negd <= negc;
    std  <= stc;
    ln   <= negd ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    ste  <= std;
  end

  assign out_valid  = ve;
  assign out_status = ste;
endmodule
`default_nettype wire

// ----- hw/rtl/ntcbt_temp.sv -----
// Beta equation denominator, pipelined long division and output clamp.
`default_nettype none
module ntcbt_temp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [ntcbt_pkg::LN_W-1:0] ln,
  input  logic [ntcbt_pkg::STATUS_W-1:0]    in_status,
  input  ntcbt_pkg::cfg_t                   cfg,
  output logic                              out_valid,
  output logic signed [ntcbt_pkg::TEMP_W-1:0] temp,
  output logic [ntcbt_pkg::STATUS_W-1:0]    out_status
);
  import ntcbt_pkg::*;

  localparam int QB = 17;       // quotient bits, enough to pass the clamp
  localparam int ND = QB + 1;   // overflow check plus one stage per bit

  logic                v1, v2;
  logic signed [38:0]  prod1;
  logic signed [39:0]  den2;
  logic [STATUS_W-1:0] st1, st2;

  logic                nonpos;
  logic [53:0]         a3;

  logic                vld [0:ND];
  logic [53:0]         rem [0:ND];
  logic [38:0]         dn  [0:ND];
  logic                sat [0:ND];
  logic [QB-1:0]       q   [0:ND];
  logic [STATUS_W-1:0] st  [0:ND];

  logic [17:0]         tcc;
  logic                over;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod1 <= ln * $signed({1'b0, cfg.t0});
    st1   <= in_status;
    den2  <= {prod1[38], prod1} + {3'd0, cfg.beta_k};
    st2   <= st1;
  end

  // numerator rounded by half the denominator
  assign nonpos = den2[39] || (den2 == '0);
  assign a3     = {1'b0, cfg.num_base, 16'd0} + {16'd0, den2[38:1]};

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= v2;
  end

  always_ff @(posedge clk) begin
    rem[0] <= a3;
    dn[0]  <= den2[38:0];
    sat[0] <= nonpos;
    q[0]   <= '0;
    st[0]  <= st2;
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [55:0] shv;
    logic        ge;

    assign shv = {17'd0, dn[j]} << (QB - j);
    assign ge  = {2'd0, rem[j]} >= shv;

    always_ff @(posedge clk) begin
      if (rst) vld[j+1] <= 1'b0;
      else     vld[j+1] <= vld[j];
    end

    if (j == 0) begin : g_ovf
      always_ff @(posedge clk) begin
        rem[j+1] <= rem[j];
        sat[j+1] <= sat[j] || ge;
        q[j+1]   <= q[j];
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        rem[j+1] <= ge ? (rem[j] - shv[53:0]) : rem[j];
        sat[j+1] <= sat[j];
        q[j+1]   <= {q[j][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      dn[j+1] <= dn[j];
      st[j+1] <= st[j];
    end
  end

  assign tcc  = {1'b0, q[ND]} - KELVIN_OFFSET_CK;
  assign over = sat[ND] || ($signed(tcc) > $signed({2'b00, TEMP_MAX_CC}));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vld[ND];
  end

  always_ff @(posedge clk) begin
    out_status <= st[ND];
    if (st[ND] != STATUS_VALID) temp <= '0;
    else if (over)              temp <= $signed(TEMP_MAX_CC);
    else                        temp <= $signed(tcc[TEMP_W-1:0]);
  end
endmodule
`default_nettype wire

// ----- tb/ntc_beta_temperature_core_tb.sv -----
// Self-checking testbench for the NTC thermistor beta-equation temperature core.
`default_nettype none
module ntc_beta_temperature_core_tb;
  import ntcbt_pkg::*;

  localparam int FULL_SCALE = ADC_FULL_SCALE_DEF;
  localparam int MIN_CC = -27315;
  localparam int MAX_CC = 32767;
  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_BETA = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_T0   = 3'd4;

  // directed codes: zero, one, full scale, midpoint, extremes of bits
  localparam int DIRECT_CODES[12] = '{0, 1, 2, 2047, 2048, 4093, 4094, 4095, 4095,
                                      1365, 2730, 4000};
  localparam int LOW_DEN_CODES[5] = '{1, 100, 2047, 4000, 4094};
  localparam int HIGH_T0_CODES[3] = '{1, 2047, 4094};

  // One expected reading: temperature plus status code.
  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [STATUS_W-1:0]      stat;
  } reading_t;

  // Beta-equation predictor with its own register copies.
  class temp_scoreboard;
    reading_t pending[$];
    bit [BETA_W-1:0] beta;
    bit [T0_W-1:0]   t0;
    int fails;

    function new();
      beta = BETA_RESET;
      t0 = T0_RESET;
      fails = 0;
    endfunction

    // log2 of a nonzero Q16.16 ratio, signed Q16.16, fraction truncated
    function longint log2_fix(bit [31:0] r);
      int msb;
      bit [63:0] mant;
      longint frac;
      msb = 31;
      frac = 0;
      while (msb > 0 && r[msb] == 1'b0) msb--;
      if (msb >= 30) mant = 64'(r) >> (msb - 30);
      else mant = 64'(r) << (30 - msb);
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant >= (64'd2 << 30)) begin
          frac = frac | 1;
          mant = mant >> 1;
        end
      end
      return longint'(msb - 16) * 65536 + frac;
    endfunction

    function reading_t predict(bit [CODE_W-1:0] code);
      reading_t res;
      bit [63:0] ratio, mag;
      longint lg, ln_q, num, den, tck, tcc;
      res.temp = '0;
      if (code == 0) begin
        res.stat = STATUS_CODE_ZERO;
        return res;
      end
      if (code >= FULL_SCALE) begin
        res.stat = STATUS_CODE_FULL;
        return res;
      end
      res.stat = STATUS_VALID;
      ratio = (64'(FULL_SCALE - code) << 16) / code;
      if (ratio == 0) ratio = 1;
      lg = log2_fix(ratio[31:0]);
      mag = ((64'(lg < 0 ? -lg : lg)) * 64'd2977044472 + (64'd1 << 31)) >> 32;
      ln_q = lg < 0 ? -longint'(mag) : longint'(mag);
      num = 100 * longint'(beta) * longint'(t0) * 65536;
      den = ln_q * longint'(t0) + 6553600 * longint'(beta);
      if (den <= 0) tcc = MAX_CC;
      else begin
        tck = (num + den / 2) / den;
        tcc = tck - 27315;
        if (tcc > MAX_CC) tcc = MAX_CC;
        if (tcc < MIN_CC) tcc = MIN_CC;
      end
      res.temp = tcc[15:0];
      return res;
    endfunction

    function void note_request(bit [CODE_W-1:0] code);
      pending.push_back(predict(code));
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] temp, logic [STATUS_W-1:0] stat);
      reading_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result temp=%0d status=%0d", temp, stat);
        fails++;
        return;
      end
      exp_r = pending.pop_front();
      if (temp !== exp_r.temp) begin
        $error("temp_centi_celsius expected %0d actual %0d", exp_r.temp, temp);
        fails++;
      end
      if (stat !== exp_r.stat) begin
        $error("status expected %0d actual %0d", exp_r.stat, stat);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CODE_W-1:0] adc_code = '0;
  logic done;
  logic signed [TEMP_W-1:0] temp_centi_celsius;
  logic [STATUS_W-1:0] status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  temp_scoreboard board = new();
  int idle_pct;  // sender idle percentage of the current phase

  ntc_beta_temperature_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results are capture-or-lose: check every done cycle at the rising edge.
  always @(posedge clk)
    if (!rst && done) board.check_result(temp_centi_celsius, status);

  // APB write: setup cycle, then access cycle; pready is always high.
  // The register is picked by address bit 2, as in the block.
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_BETA) board.beta = val[BETA_W-1:0];
    else board.t0 = val[T0_W-1:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Send one request; start stays high across back-to-back requests.
  task automatic send_code(logic [CODE_W-1:0] code);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    adc_code <= code;
    do @(posedge clk); while (busy);
    board.note_request(code);
    @(negedge clk);
  endtask

  // Let the pipeline empty before touching registers.
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (TOTAL_LAT + 4) @(negedge clk);
  endtask

  // Mostly codes spread over the full range, with some near either end.
  function automatic logic [CODE_W-1:0] rand_code();
    case ($urandom_range(9))
      0: return CODE_W'($urandom_range(40));
      1: return CODE_W'($urandom_range(4095, 4050));
      default: return CODE_W'($urandom);
    endcase
  endfunction

  initial begin
    idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECT_CODES); i++)
      send_code(CODE_W'(DIRECT_CODES[i]));
    drain();
    // absurdly low beta and zero T0 drive the denominator to zero
    reg_write(ADDR_BETA, 32'd0);
    reg_write(ADDR_T0, 32'd0);
    for (int i = 0; i < $size(LOW_DEN_CODES); i++)
      send_code(CODE_W'(LOW_DEN_CODES[i]));
    drain();
    reg_write(ADDR_BETA, 32'd1);
    reg_write(ADDR_T0, 32'hFFFF_FFFF);
    for (int i = 0; i < $size(HIGH_T0_CODES); i++)
      send_code(CODE_W'(HIGH_T0_CODES[i]));
    drain();
    reg_write(3'd2, 32'd12345);  // unaligned address: decodes as beta
    reg_write(ADDR_BETA, 32'h0000_3FFF);

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin reg_write(ADDR_BETA, 32'd1000); reg_write(ADDR_T0, 32'd20000); end
        1: begin reg_write(ADDR_BETA, 32'd10000); reg_write(ADDR_T0, 32'd40000); end
        2: begin reg_write(ADDR_BETA, 32'd3905); reg_write(ADDR_T0, 32'd29815); end
        default: begin
          reg_write(ADDR_BETA, $urandom);
          reg_write(ADDR_T0, $urandom);
        end
      endcase
      idle_pct = (ph < 2) ? 18 : (ph < 4) ? 61 : 0;
      repeat (255) send_code(rand_code());
    end

    start <= 1'b0;
    drain();
    if (board.fails == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
